@@ src/frustum_cull_test_defines.svh @@
// Assertion macros used by the frustum cull top level.
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, sampled on clk_i, off while in reset
`define FCT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("frustum_cull_test: assertion failed");

// Next-cycle implication, sampled on clk_i, off while in reset
`define FCT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("frustum_cull_test: assertion failed");

`else

`define FCT_ASSERT_IMPLY(lbl, ante, cons)
`define FCT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

@@ src/fct_pkg.sv @@
// Types, constants and handshake structs of the frustum cull unit.
package fct_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int COORD_WIDTH = 32;
  localparam int PLANE_W     = $clog2(NUM_PLANES);
  localparam int IDX_W       = 3;
  localparam int RAD_W       = COORD_WIDTH - 1;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  // Three products plus D and radius terms: three bits of growth
  localparam int DIST_W      = PROD_W + 3;
  localparam int FRAC_W      = 16;
  localparam int IN_DATA_W   = 264;
  localparam int OUT_DATA_W  = 8;

  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_SPHERE = 2'd1,
    REQ_BOX    = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  localparam logic KIND_SPHERE = 1'b0;
  localparam logic KIND_BOX    = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_RES
  } state_e;

  // Input tdata layout, most significant member first
  typedef struct packed {
    logic [IN_DATA_W-(IDX_W+7*COORD_WIDTH+RAD_W)-1:0] pad;
    logic [RAD_W-1:0]              radius;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] coef_d;
    logic signed [COORD_WIDTH-1:0] coef_c;
    logic signed [COORD_WIDTH-1:0] coef_b;
    logic signed [COORD_WIDTH-1:0] coef_a;
    logic [IDX_W-1:0]              plane_index;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] a;
    logic signed [COORD_WIDTH-1:0] b;
    logic signed [COORD_WIDTH-1:0] c;
    logic signed [COORD_WIDTH-1:0] d;
  } plane_t;

  // Controller to datapath
  typedef struct packed {
    logic               in_ready;
    logic               load;
    logic               mul_en;
    logic [PLANE_W-1:0] plane_sel;
    logic               emit;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    req_e req;
    logic last;
    logic out_free;
  } status_t;

endpackage

@@ src/frustum_cull_test.sv @@
// Top level of the sphere / box view-frustum cull unit.
//
//  channel   dir  tdata                                           tuser        tlast
//  s_axis    in   plane_index, coef_a..d, pos_x..z, radius, pad   req_type     last_corner
//  m_axis    out  visible, pad                                    result_kind  -
//
// A plane write or an unknown request is taken in the idle state. A sphere test or a box
// corner passes through the accept state, then the shared three-multiplier stage
// handles one plane per cycle, then one adder state and one result state. The result
// state waits while the output register still holds an untaken transaction; a new
// input is taken while a result waits downstream.
// Reset clears the plane table, the corner flags and all handshake state.
module frustum_cull_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // plane_index[2:0], coef_a[34:3], coef_b[66:35], coef_c[98:67], coef_d[130:99],
  // pos_x[162:131], pos_y[194:163], pos_z[226:195], radius[257:227], zeros above
  input  logic [fct_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // req_type[1:0]
  input  logic [1:0]                    s_axis_tuser_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // visible[0], zeros above
  output logic [fct_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // result_kind[0]
  output logic                          m_axis_tuser_o
);
  import fct_pkg::*;

`include "frustum_cull_test_defines.svh"

  ctrl_t   ctrl;
  status_t status;
  req_e    in_req;

  assign in_req          = req_e'(s_axis_tuser_i);
  assign s_axis_tready_o = ctrl.in_ready;

  fct_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .in_req_i        (in_req),
    .status_i        (status),
    .ctrl_o          (ctrl)
  );

  fct_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .in_req_i        (in_req),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // No input taken while the multiply stage is busy
  `FCT_ASSERT_IMPLY(a_no_accept_while_busy, ctrl.mul_en, !s_axis_tready_o)
  // A verdict only goes out when the output register is free
  `FCT_ASSERT_IMPLY(a_emit_needs_slot, ctrl.emit, status.out_free)
  // A sphere or box transaction starts the plane sweep in the next cycle
  `FCT_ASSERT_NEXT(a_test_starts_sweep,
                   s_axis_tvalid_i && s_axis_tready_o &&
                   (in_req == REQ_SPHERE || in_req == REQ_BOX),
                   ctrl.mul_en)

endmodule

@@ src/fct_ctrl.sv @@
// Sequencer: walks the plane table once per test and schedules the verdict.
module fct_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  input  fct_pkg::req_e    in_req_i,
  input  fct_pkg::status_t status_i,
  output fct_pkg::ctrl_t   ctrl_o
);
  import fct_pkg::*;

  localparam logic [PLANE_W-1:0] LastPlane = PLANE_W'(NUM_PLANES - 1);

  state_e             state_q, state_d;
  logic [PLANE_W-1:0] cnt_q, cnt_d;
  logic               load;
  logic               need_result;

  assign load        = (state_q == ST_IDLE) && s_axis_tvalid_i;
  assign need_result = (status_i.req == REQ_SPHERE) ||
                       ((status_i.req == REQ_BOX) && status_i.last);

  // Next state and plane counter
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (load && (in_req_i == REQ_SPHERE || in_req_i == REQ_BOX)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (cnt_q == LastPlane) begin
          state_d = ST_ADD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ADD: state_d = ST_RES;
      ST_RES: begin
        if (!need_result || status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Commands to the datapath
  always_comb begin
    ctrl_o           = '0;
    ctrl_o.plane_sel = cnt_q;
    case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.load     = load;
      end
      ST_MUL:  ctrl_o.mul_en = 1'b1;
      ST_ADD:  ctrl_o.mul_en = 1'b0;
      ST_RES:  ctrl_o.emit   = need_result && status_i.out_free;
      default: ctrl_o.emit   = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ src/fct_datapath.sv @@
// Plane table, multiply stage, distance adder, corner flags and result register.
module fct_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fct_pkg::ctrl_t                    ctrl_i,
  output fct_pkg::status_t                  status_o,
  input  logic [fct_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  fct_pkg::req_e                     in_req_i,
  input  logic                              s_axis_tlast_i,
  input  logic                              m_axis_tready_i,
  output logic                              m_axis_tvalid_o,
  output logic [fct_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tuser_o
);
  import fct_pkg::*;

  in_item_t item;
  assign item = in_item_t'(s_axis_tdata_i);

  plane_t                  plane_q [NUM_PLANES];
  req_e                    req_q;
  logic                    last_q;
  logic signed [COORD_WIDTH-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic [RAD_W-1:0]        radius_q;

  logic signed [PROD_W-1:0]      prod_a_q, prod_b_q, prod_c_q;
  logic signed [COORD_WIDTH-1:0] d_q;
  logic [PLANE_W-1:0]            prod_plane_q;
  logic                          prod_vld_q;

  logic signed [DIST_W-1:0] dist_sum;
  logic [DIST_W-1:0]        d_term, bias_term;
  logic                     dist_neg;

  logic [NUM_PLANES-1:0] flags_q;
  logic                  vis_q;
  logic                  out_vld_q, out_vis_q, out_kind_q;
  plane_t                plane_rd;

  // Plane table, loaded by write transactions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_q[i] <= '0;
      end
    end else if (ctrl_i.load && in_req_i == REQ_WRITE &&
                 int'(item.plane_index) < NUM_PLANES) begin
      plane_q[item.plane_index[PLANE_W-1:0]] <= '{a: item.coef_a, b: item.coef_b,
                                                  c: item.coef_c, d: item.coef_d};
    end
  end

  // Item operands held for the whole test
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      pos_x_q  <= item.pos_x;
      pos_y_q  <= item.pos_y;
      pos_z_q  <= item.pos_z;
      radius_q <= item.radius;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q  <= REQ_NONE;
      last_q <= 1'b0;
    end else if (ctrl_i.load) begin
      req_q  <= in_req_i;
      last_q <= s_axis_tlast_i;
    end
  end

  // Multiply stage: one plane per cycle
  assign plane_rd = plane_q[ctrl_i.plane_sel];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_a_q     <= plane_rd.a * pos_x_q;
      prod_b_q     <= plane_rd.b * pos_y_q;
      prod_c_q     <= plane_rd.c * pos_z_q;
      d_q          <= plane_rd.d;
      prod_plane_q <= ctrl_i.plane_sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
    end
  end

  // Exact Q35.32 distance, radius bias for spheres only
  assign d_term    = {{(DIST_W-COORD_WIDTH-FRAC_W){d_q[COORD_WIDTH-1]}}, d_q, {FRAC_W{1'b0}}};
  assign bias_term = (req_q == REQ_SPHERE) ?
                     DIST_W'({radius_q, {FRAC_W{1'b0}}}) : '0;
  assign dist_sum  = DIST_W'(prod_a_q) + DIST_W'(prod_b_q) + DIST_W'(prod_c_q)
                   + $signed(d_term) + $signed(bias_term);
  assign dist_neg  = dist_sum[DIST_W-1];

  // Sphere verdict and per-plane corner flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vis_q   <= 1'b1;
      flags_q <= '0;
    end else begin
      if (ctrl_i.load) begin
        vis_q <= 1'b1;
      end else if (prod_vld_q && req_q == REQ_SPHERE && dist_neg) begin
        vis_q <= 1'b0;
      end
      if (ctrl_i.emit && req_q == REQ_BOX) begin
        flags_q <= '0;
      end else if (prod_vld_q && req_q == REQ_BOX && !dist_neg) begin
        flags_q[prod_plane_q] <= 1'b1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_kind_q <= (req_q == REQ_BOX) ? KIND_BOX : KIND_SPHERE;
      out_vis_q  <= (req_q == REQ_BOX) ? (&flags_q) : vis_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-1){1'b0}}, out_vis_q};
  assign m_axis_tuser_o  = out_kind_q;

  assign status_o.req      = req_q;
  assign status_o.last     = last_q;
  assign status_o.out_free = !out_vld_q || m_axis_tready_i;

endmodule
